// File: rtl/aapr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation package
// Shared widths, payload types, codes and the sine and cosine tables.
// ----------------------------------------------------------------------------
package aapr_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int ANGLE_W    = 9;
  localparam int AXIS_W     = 16;
  localparam int AXIS_FRAC  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int TRIG_W    = TRIG_FRAC_BITS + 2;
  localparam int TAB_W     = TRIG_FRAC_BITS + 1;
  localparam int TAB_DEPTH = 90;
  localparam int TAB_IDX_W = $clog2(TAB_DEPTH);

  localparam int SQR_W     = 2 * AXIS_W;
  localparam int LEN_W     = 2 * AXIS_W;
  localparam int SQ_SHIFT  = 28;
  localparam int RAD_W     = LEN_W + SQ_SHIFT;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int NUM_W     = TRIG_FRAC_BITS + 34;
  localparam int NUM_TERMS = 9;
  localparam int TERM_IDX_W = $clog2(NUM_TERMS);
  localparam int MW        = TRIG_FRAC_BITS + 4;
  localparam int PROD_W    = MW + COORD_WIDTH;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic [ANGLE_W-1:0] DEG_FULL = ANGLE_W'(360);
  localparam logic [ANGLE_W-1:0] DEG_HALF = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_3Q   = ANGLE_W'(270);
  localparam logic [ANGLE_W-1:0] DEG_QUAD = ANGLE_W'(90);

  localparam logic signed [TRIG_W:0] ONE_TRIG = (TRIG_W + 1)'(1) <<< TRIG_FRAC_BITS;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182, 64'd240};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE  = 2'd0,
    REG_AXIS_U = 2'd1,
    REG_AXIS_V = 2'd2,
    REG_AXIS_W = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_SQUARE,
    ST_LENGTH,
    ST_PRODUCT,
    ST_NUMER,
    ST_ROOT,
    ST_DLOAD,
    ST_DRUN,
    ST_MATRIX,
    ST_DONE
  } setup_state_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;
    logic                          axis_zero;
  } result_t;

  typedef struct packed {
    logic en1;
    logic en2;
  } pipe_ctl_t;

  typedef struct packed {
    logic ready;
    logic zero;
  } setup_sts_t;

  typedef logic [TAB_W-1:0] trig_tab_t [TAB_DEPTH];

  // Long division by shift and subtract, used only while the tables are built.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [TAB_W-1:0] series_q(input logic [63:0] x, input logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x + 64'd536870912) >> 30;
    term = odd ? x : ONE_Q30;
    sum  = $signed(term);
    for (int n = 0; n < 8; n++) begin
      term = udiv64((term * x2) >> 30, odd ? SIN_DIV[n] : COS_DIV[n]);
      if (!n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    return TAB_W'(($unsigned(sum) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                  >> (30 - TRIG_FRAC_BITS));
  endfunction

  function automatic trig_tab_t build_tab(input logic odd);
    trig_tab_t   t;
    logic [63:0] x;
    for (int r = 0; r < TAB_DEPTH; r++) begin
      x    = (64'(r) * PI_Q30 + 64'd90) / 64'd180;
      t[r] = series_q(x, odd);
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b1);
  localparam trig_tab_t COS_TAB = build_tab(1'b0);

  localparam logic signed [ACC_W:0] SAT_HI =
    {{(ACC_W - COORD_WIDTH + 2){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO =
    {{(ACC_W - COORD_WIDTH + 2){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  // Divides by the trig scale, rounding half away from zero, then saturates.
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic               neg;
    logic [ACC_W-1:0]   mag;
    logic [ACC_W-1:0]   quo;
    logic signed [ACC_W:0] res;
    neg = acc[ACC_W-1];
    mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
    quo = (mag + (ACC_W'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    res = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (res > SAT_HI) begin
      res = SAT_HI;
    end
    if (res < SAT_LO) begin
      res = SAT_LO;
    end
    return res[COORD_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/axis_angle_point_rotation.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation
// Rotates Q8.8 points about a configured axis through the origin.
// ----------------------------------------------------------------------------
// The configuration channel writes the angle in degrees and the three axis
// components; it is always ready. Every write restarts the matrix setup,
// which runs the axis length, its square root and nine divisions on shared
// iterative units; the divider yields one quotient bit per cycle. The input
// channel stalls during setup. The same setup runs after reset, for the
// reset axis and angle.
// Once the matrix is ready, one point word is accepted per cycle unless the
// receiver stalls. Three row lanes multiply and sum in two stages, and an
// output register rounds and saturates, so each point passes the product,
// sum and output registers in turn.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling until each holds a word; only then does the input stall.
// A zero axis gives zero coordinates with the axis_zero flag set.
// ----------------------------------------------------------------------------
module axis_angle_point_rotation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aapr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [aapr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  aapr_pkg::point_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output aapr_pkg::result_t                    out_data_o
);
  import aapr_pkg::*;

  logic [ANGLE_W-1:0]       angle_q;
  logic signed [AXIS_W-1:0] u_q, v_q, w_q;
  logic                     cfg_wr;

  setup_sts_t               sts;
  logic signed [MW-1:0]     mat [3][3];
  logic signed [ACC_W-1:0]  sums [3];

  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  logic      accept;
  pipe_ctl_t ctl;
  result_t   out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      u_q     <= '0;
      v_q     <= '0;
      w_q     <= AXIS_W'(16384);
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ANGLE:  angle_q <= cfg_data_i[ANGLE_W-1:0];
        REG_AXIS_U: u_q     <= $signed(cfg_data_i[AXIS_W-1:0]);
        REG_AXIS_V: v_q     <= $signed(cfg_data_i[AXIS_W-1:0]);
        REG_AXIS_W: w_q     <= $signed(cfg_data_i[AXIS_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  aapr_setup u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .angle_i   (angle_q),
    .u_i       (u_q),
    .v_i       (v_q),
    .w_i       (w_q),
    .sts_o     (sts),
    .mat_o     (mat)
  );

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1 || !sts.ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign ctl.en1    = rdy1 && accept;
  assign ctl.en2    = rdy2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= accept;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_lane
    aapr_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .point_i (in_data_i),
      .row_i   (mat[r]),
      .sum_o   (sums[r])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_q.rotated_x <= sts.zero ? '0 : round_sat(sums[0]);
      out_q.rotated_y <= sts.zero ? '0 : round_sat(sums[1]);
      out_q.rotated_z <= sts.zero ? '0 : round_sat(sums[2]);
      out_q.axis_zero <= sts.zero;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/aapr_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aapr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aapr_pkg::NUM_W-1:0] num_i,
  input  logic [aapr_pkg::LEN_W-1:0] den_i,
  output logic                       done_o,
  output logic [aapr_pkg::NUM_W-1:0] quot_o
);
  import aapr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [LEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [LEN_W-1:0] den_q;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/aapr_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module aapr_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aapr_pkg::RAD_W-1:0]  rad_i,
  output logic                        done_o,
  output logic [aapr_pkg::ROOT_W-1:0] root_o
);
  import aapr_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [RAD_W-1:0] sbit_q;
  logic [RAD_W-1:0] a_q;
  logic [RAD_W-1:0] res_q;
  logic [RAD_W-1:0] rb;
  logic             ge;

  assign rb = res_q + sbit_q;
  assign ge = a_q >= rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sbit_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sbit_q <= RAD_W'(1) << (RAD_W - 2);
      end else if (busy_q) begin
        sbit_q <= sbit_q >> 2;
        if (sbit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= rad_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        a_q   <= a_q - rb;
        res_q <= (res_q >> 1) + sbit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// File: rtl/aapr_setup.sv
// ----------------------------------------------------------------------------
// Rotation matrix setup
// Builds the normalized axis-angle matrix from the configuration registers.
// ----------------------------------------------------------------------------
module aapr_setup (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic [aapr_pkg::ANGLE_W-1:0]       angle_i,
  input  logic signed [aapr_pkg::AXIS_W-1:0] u_i,
  input  logic signed [aapr_pkg::AXIS_W-1:0] v_i,
  input  logic signed [aapr_pkg::AXIS_W-1:0] w_i,
  output aapr_pkg::setup_sts_t               sts_o,
  output logic signed [aapr_pkg::MW-1:0]     mat_o [3][3]
);
  import aapr_pkg::*;

  localparam logic [TERM_IDX_W-1:0] LAST_TERM = TERM_IDX_W'(NUM_TERMS - 1);
  localparam logic [TERM_IDX_W-1:0] SQ_TERM   = TERM_IDX_W'(6);

  setup_state_e state_q, state_d;
  logic root_start, root_done, div_start, div_done;

  logic [ANGLE_W-1:0]          deg;
  logic [1:0]                  quad;
  logic [TAB_IDX_W-1:0]        ridx;
  logic signed [TRIG_W-1:0]    sr, cr, s_d, c_d;

  logic [SQR_W-1:0]            uu_q, vv_q, ww_q;
  logic signed [TRIG_W-1:0]    s_q, c_q;
  logic [LEN_W-1:0]            len2_q, vpw_q, upw_q, upv_q;
  logic signed [SQR_W-1:0]     uv_q, uw_q, vw_q;
  logic signed [AXIS_W+TRIG_W-1:0] us_q, vs_q, ws_q;
  logic signed [TRIG_W:0]      k_q;
  logic signed [NUM_W-1:0]     pd_q [3];
  logic signed [NUM_W-1:0]     num_q [NUM_TERMS];
  logic signed [MW-1:0]        qr_q [NUM_TERMS];
  logic signed [MW-1:0]        mat_q [3][3];
  logic [TERM_IDX_W-1:0]       idx_q;
  logic                        zero_q;
  logic                        dneg_q;

  logic [ROOT_W-1:0]           root;
  logic [NUM_W-1:0]            quot;
  logic signed [NUM_W-1:0]     nsel;
  logic [NUM_W-1:0]            nmag;
  logic [LEN_W-1:0]            den;
  logic [NUM_W-1:0]            div_num;
  logic [MW-1:0]               qtrunc;

  always_comb begin
    deg = (angle_i >= DEG_FULL) ? angle_i - DEG_FULL : angle_i;
    if (deg < DEG_QUAD) begin
      quad = 2'd0;
      ridx = TAB_IDX_W'(deg);
    end else if (deg < DEG_HALF) begin
      quad = 2'd1;
      ridx = TAB_IDX_W'(deg - DEG_QUAD);
    end else if (deg < DEG_3Q) begin
      quad = 2'd2;
      ridx = TAB_IDX_W'(deg - DEG_HALF);
    end else begin
      quad = 2'd3;
      ridx = TAB_IDX_W'(deg - DEG_3Q);
    end
    sr = $signed({1'b0, SIN_TAB[ridx]});
    cr = $signed({1'b0, COS_TAB[ridx]});
    case (quad)
      2'd0: begin
        s_d = sr;
        c_d = cr;
      end
      2'd1: begin
        s_d = cr;
        c_d = -sr;
      end
      2'd2: begin
        s_d = -sr;
        c_d = -cr;
      end
      default: begin
        s_d = -cr;
        c_d = sr;
      end
    endcase
  end

  always_comb begin
    nsel    = num_q[idx_q];
    nmag    = nsel[NUM_W-1] ? NUM_W'(-nsel) : NUM_W'(nsel);
    den     = (idx_q >= SQ_TERM) ? LEN_W'(root) : len2_q;
    div_num = nmag + NUM_W'(den >> 1);
    qtrunc  = quot[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SQUARE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    root_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_SQUARE:  state_d = ST_LENGTH;
      ST_LENGTH:  state_d = ST_PRODUCT;
      ST_PRODUCT: state_d = ST_NUMER;
      ST_NUMER: begin
        if (len2_q == '0) begin
          state_d = ST_DONE;
        end else begin
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        div_start = 1'b1;
        state_d   = ST_DRUN;
      end
      ST_DRUN: begin
        if (div_done) begin
          state_d = (idx_q == LAST_TERM) ? ST_MATRIX : ST_DLOAD;
        end
      end
      ST_MATRIX: state_d = ST_DONE;
      ST_DONE:   state_d = ST_DONE;
      default:   state_d = ST_SQUARE;
    endcase
    if (restart_i) begin
      state_d = ST_SQUARE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      case (state_q)
        ST_NUMER: begin
          idx_q  <= '0;
          zero_q <= (len2_q == '0);
        end
        ST_DRUN: begin
          if (div_done) begin
            idx_q <= idx_q + TERM_IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SQUARE: begin
        uu_q <= u_i * u_i;
        vv_q <= v_i * v_i;
        ww_q <= w_i * w_i;
        s_q  <= s_d;
        c_q  <= c_d;
      end
      ST_LENGTH: begin
        len2_q <= uu_q + vv_q + ww_q;
        vpw_q  <= vv_q + ww_q;
        upw_q  <= uu_q + ww_q;
        upv_q  <= uu_q + vv_q;
        uv_q   <= u_i * v_i;
        uw_q   <= u_i * w_i;
        vw_q   <= v_i * w_i;
        us_q   <= u_i * s_q;
        vs_q   <= v_i * s_q;
        ws_q   <= w_i * s_q;
        k_q    <= ONE_TRIG - (TRIG_W + 1)'(c_q);
      end
      ST_PRODUCT: begin
        pd_q[0]  <= $signed({1'b0, vpw_q}) * c_q;
        pd_q[1]  <= $signed({1'b0, upw_q}) * c_q;
        pd_q[2]  <= $signed({1'b0, upv_q}) * c_q;
        num_q[3] <= uv_q * k_q;
        num_q[4] <= uw_q * k_q;
        num_q[5] <= vw_q * k_q;
        num_q[6] <= us_q <<< AXIS_FRAC;
        num_q[7] <= vs_q <<< AXIS_FRAC;
        num_q[8] <= ws_q <<< AXIS_FRAC;
      end
      ST_NUMER: begin
        num_q[0] <= (NUM_W'(uu_q) << TRIG_FRAC_BITS) + pd_q[0];
        num_q[1] <= (NUM_W'(vv_q) << TRIG_FRAC_BITS) + pd_q[1];
        num_q[2] <= (NUM_W'(ww_q) << TRIG_FRAC_BITS) + pd_q[2];
      end
      ST_DLOAD: begin
        dneg_q <= nsel[NUM_W-1];
      end
      ST_DRUN: begin
        if (div_done) begin
          qr_q[idx_q] <= dneg_q ? -$signed(qtrunc) : $signed(qtrunc);
        end
      end
      ST_MATRIX: begin
        mat_q[0][0] <= qr_q[0];
        mat_q[1][1] <= qr_q[1];
        mat_q[2][2] <= qr_q[2];
        mat_q[0][1] <= qr_q[3] - qr_q[8];
        mat_q[1][0] <= qr_q[3] + qr_q[8];
        mat_q[0][2] <= qr_q[4] + qr_q[7];
        mat_q[2][0] <= qr_q[4] - qr_q[7];
        mat_q[1][2] <= qr_q[5] - qr_q[6];
        mat_q[2][1] <= qr_q[5] + qr_q[6];
      end
      default: begin
      end
    endcase
  end

  aapr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   ({len2_q, {SQ_SHIFT{1'b0}}}),
    .done_o  (root_done),
    .root_o  (root)
  );

  aapr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sts_o.ready = (state_q == ST_DONE);
  assign sts_o.zero  = zero_q;
  assign mat_o       = mat_q;

endmodule

// File: rtl/aapr_lane.sv
// ----------------------------------------------------------------------------
// Matrix row lane
// Multiplies one matrix row by the point and sums the three products.
// ----------------------------------------------------------------------------
module aapr_lane (
  input  logic                              clk_i,
  input  aapr_pkg::pipe_ctl_t               ctl_i,
  input  aapr_pkg::point_t                  point_i,
  input  logic signed [aapr_pkg::MW-1:0]    row_i [3],
  output logic signed [aapr_pkg::ACC_W-1:0] sum_o
);
  import aapr_pkg::*;

  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [ACC_W-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      prod_q[0] <= row_i[0] * point_i.point_x;
      prod_q[1] <= row_i[1] * point_i.point_y;
      prod_q[2] <= row_i[2] * point_i.point_z;
    end
    if (ctl_i.en2) begin
      sum_q <= prod_q[0] + prod_q[1] + prod_q[2];
    end
  end

  assign sum_o = sum_q;

endmodule

// File: tb/tb_axis_angle_point_rotation.sv
// ----------------------------------------------------------------------------
// Axis-angle point rotation testbench
// Drives point words through several axis and angle settings, predicts each
// rotated point with an independent fixed-point model, and compares results
// in order, with and without random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_axis_angle_point_rotation;
  import aapr_pkg::*;

  class rotation_scoreboard;
    logic [8:0]         angle;
    logic signed [15:0] ax_u, ax_v, ax_w;
    result_t            pending[$];
    int                 mismatches;

    function new();
      angle = '0;
      ax_u = '0;
      ax_v = '0;
      ax_w = 16'sd16384;
      mismatches = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        REG_ANGLE:  angle = val[8:0];
        REG_AXIS_U: ax_u = val;
        REG_AXIS_V: ax_v = val;
        REG_AXIS_W: ax_w = val;
        default: ;
      endcase
    endfunction

    function longint div_round(longint n, longint d);
      longint q;
      q = ((n < 0 ? -n : n) + d / 2) / d;
      return n < 0 ? -q : q;
    endfunction

    function longint int_sqrt(longint unsigned a);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv >>= 2;
      while (bitv != 0) begin
        if (a >= res + bitv) begin
          a -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint taylor_q14(longint unsigned x, bit odd);
      longint unsigned x2, term, dv;
      longint sum;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = odd ? x : 64'd1073741824;
      sum = term;
      for (int n = 1; n <= 8; n++) begin
        dv = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
        term = ((term * x2) >> 30) / dv;
        if (n % 2 == 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > 1073741824) sum = 1073741824;
      return (sum + (64'd1 << 15)) >> 16;
    endfunction

    function void note_point(point_t p);
      result_t r;
      longint u, v, w, len2, d, sr, cr, s, c, k, sq, uvk, uwk, vwk, us, vs, ws;
      longint m[3][3];
      longint pt[3];
      longint acc, res;
      longint unsigned x;
      u = ax_u;
      v = ax_v;
      w = ax_w;
      len2 = u * u + v * v + w * w;
      r = '0;
      if (len2 == 0) begin
        r.axis_zero = 1'b1;
        pending.push_back(r);
        return;
      end
      d = angle % 360;
      x = ((d % 90) * 64'd3373259426 + 90) / 180;
      sr = taylor_q14(x, 1'b1);
      cr = taylor_q14(x, 1'b0);
      case (d / 90)
        0: begin s = sr; c = cr; end
        1: begin s = cr; c = -sr; end
        2: begin s = -sr; c = -cr; end
        default: begin s = -cr; c = sr; end
      endcase
      k = 16384 - c;
      sq = int_sqrt(len2 << 28);
      uvk = div_round(u * v * k, len2);
      uwk = div_round(u * w * k, len2);
      vwk = div_round(v * w * k, len2);
      us = div_round(u * s * 16384, sq);
      vs = div_round(v * s * 16384, sq);
      ws = div_round(w * s * 16384, sq);
      m[0][0] = div_round(u * u * 16384 + (v * v + w * w) * c, len2);
      m[0][1] = uvk - ws;
      m[0][2] = uwk + vs;
      m[1][0] = uvk + ws;
      m[1][1] = div_round(v * v * 16384 + (u * u + w * w) * c, len2);
      m[1][2] = vwk - us;
      m[2][0] = uwk - vs;
      m[2][1] = vwk + us;
      m[2][2] = div_round(w * w * 16384 + (u * u + v * v) * c, len2);
      pt[0] = p.point_x;
      pt[1] = p.point_y;
      pt[2] = p.point_z;
      for (int i = 0; i < 3; i++) begin
        acc = m[i][0] * pt[0] + m[i][1] * pt[1] + m[i][2] * pt[2];
        res = div_round(acc, 16384);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        case (i)
          0: r.rotated_x = res[15:0];
          1: r.rotated_y = res[15:0];
          default: r.rotated_z = res[15:0];
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected x=%0d y=%0d z=%0d zero=%0b, got x=%0d y=%0d z=%0d zero=%0b",
                   exp_r.rotated_x, exp_r.rotated_y, exp_r.rotated_z, exp_r.axis_zero,
                   got.rotated_x, got.rotated_y, got.rotated_z, got.axis_zero);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  point_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  result_t out_data_o;

  rotation_scoreboard rot_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;

  always #5 clk_i = ~clk_i;

  axis_angle_point_rotation dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) rot_sb.check_result(out_data_o);
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_register(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    rot_sb.set_register(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Entered and left at a falling edge; valid stays high between words unless a random idle drops it.
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    rot_sb.note_point(p);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (rot_sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_axis(logic [8:0] ang, logic [15:0] u, logic [15:0] v, logic [15:0] w);
    drain_results();
    write_register(REG_ANGLE, {7'd0, ang});
    write_register(REG_AXIS_U, u);
    write_register(REG_AXIS_V, v);
    write_register(REG_AXIS_W, w);
  endtask

  function automatic point_t random_point();
    point_t p;
    p.point_x = 16'($urandom);
    p.point_y = 16'($urandom);
    p.point_z = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      p.point_x = $signed(p.point_x) >>> $urandom_range(8);
      p.point_y = $signed(p.point_y) >>> $urandom_range(8);
      p.point_z = $signed(p.point_z) >>> $urandom_range(8);
    end
    return p;
  endfunction

  task automatic random_setting();
    logic [8:0] ang;
    ang = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 360)) : 9'($urandom_range(359));
    set_axis(ang, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    point_t p;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset setting, field extremes, quadrants, wrap, zero axis.
    send_point('{16'sh7fff, 16'sh8000, 16'sh0100});
    send_point('{16'sh8000, 16'sh7fff, 16'sh7fff});
    set_axis(9'd90, 16'h0000, 16'h0000, 16'h4000);
    send_point('{16'sh0100, 16'sh0000, 16'sh0000});
    send_point('{16'sh7fff, 16'sh7fff, 16'sh8000});
    set_axis(9'd180, 16'h4000, 16'h0000, 16'h0000);
    send_point('{16'sh0100, 16'sh0200, 16'sh0300});
    set_axis(9'd270, 16'h7fff, 16'h8000, 16'h7fff);
    send_point('{16'sh8000, 16'sh8000, 16'sh8000});
    send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    set_axis(9'd511, 16'h8000, 16'h8000, 16'h8000);
    send_point('{16'sh1234, 16'shedcb, 16'sh0001});
    set_axis(9'd359, 16'h0001, 16'hffff, 16'h0000);
    send_point('{16'sh7fff, 16'sh0000, 16'sh8000});
    set_axis(9'd45, 16'h0000, 16'h0000, 16'h0000);
    send_point('{16'sh7fff, 16'sh8000, 16'sh1111});
    send_point('{16'sh0000, 16'sh0000, 16'sh0000});
    set_axis(9'd360, 16'h2000, 16'h2000, 16'h2000);
    send_point('{16'sh0100, 16'shff00, 16'sh0080});

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 26 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        random_setting();
        if (blk == 2) hold_off_cycles = 60;
        for (int i = 0; i < 52; i++) begin
          p = random_point();
          send_point(p);
        end
      end
    end
    drain_results();
    if (rot_sb.mismatches == 0 && rot_sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
rtl/aapr_pkg.sv
rtl/aapr_div.sv
rtl/aapr_isqrt.sv
rtl/aapr_setup.sv
rtl/aapr_lane.sv
rtl/axis_angle_point_rotation.sv
tb/tb_axis_angle_point_rotation.sv
